FILE: hw/rtl/arp_pkg.sv
// ----------------------------------------------------------------------------
// arp_pkg
// Shared types, constants and helpers for the regularised Adam update block.
// ----------------------------------------------------------------------------
package arp_pkg;

  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_AW    = 2;
  localparam int unsigned SQ_BITS    = 41;
  localparam int unsigned DIV_BITS   = 32;

  localparam logic [16:0] ONE_Q16  = 17'd65536;
  localparam logic [15:0] B1_Q16   = 16'd58982;
  localparam logic [15:0] C1_Q16   = 16'd6554;
  localparam logic [23:0] B2_Q24   = 24'd16760440;
  localparam logic [14:0] C2_Q24   = 15'd16776;
  localparam logic [40:0] EPS_Q28  = 41'd16;
  localparam logic [47:0] MAX48    = 48'hFFFF_FFFF_FFFF;

  typedef enum logic [2:0] {
    REG_LAMBDA_FIELD     = 3'd0,
    REG_LAMBDA_COUPLING  = 3'd1,
    REG_L2_MIX           = 3'd2,
    REG_RATE_FIELD       = 3'd3,
    REG_RATE_COUPLING    = 3'd4,
    REG_BIAS_CORR_FIRST  = 3'd5,
    REG_BIAS_CORR_SECOND = 3'd6
  } cfg_reg_t;

  typedef struct packed {
    logic [31:0] lam_f;
    logic [31:0] lam_c;
    logic [16:0] l2_mix;
    logic [31:0] rate_f;
    logic [31:0] rate_c;
    logic [31:0] corr1;
    logic [31:0] corr2;
  } cfg_t;

  typedef struct packed {
    logic               coup;
    logic signed [31:0] p;
    logic signed [31:0] m1n;
    logic signed [31:0] g;
    logic [47:0]        m2n;
    logic [47:0]        tsq;
    logic [47:0]        vsq;
  } item_t;

  function automatic logic signed [31:0] sat32(input logic signed [49:0] v);
    logic signed [31:0] r;
    if (v > 50'sd2147483647) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < -50'sd2147483648) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

FILE: hw/rtl/arp_front.sv
// ----------------------------------------------------------------------------
// arp_front
// Eight-stage front: regularisation, deltas, gradient, moments, errors.
// ----------------------------------------------------------------------------
module arp_front (
  input  logic                clk,
  input  logic                rst_n,
  input  arp_pkg::cfg_t       cfg,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                is_coupling,
  input  logic [16:0]         sample_freq,
  input  logic [16:0]         train_freq,
  input  logic [16:0]         valid_freq,
  input  logic signed [31:0]  old_param,
  input  logic signed [31:0]  old_first_moment,
  input  logic [47:0]         old_second_moment,
  input  logic                fifo_full,
  output logic                wr_en,
  output arp_pkg::item_t      wr_item
);

  logic [7:0] v_r;
  logic       fen;

  assign fen      = !(v_r[7] && fifo_full);
  assign in_stall = !fen;
  assign wr_en    = v_r[7] && fen;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (fen) begin
      v_r <= {v_r[6:0], in_valid};
    end
  end

  // stage 1
  logic [16:0]        alpha;
  logic signed [49:0] ap;
  logic [31:0]        l1;
  logic signed [50:0] s_c;
  logic               f1_coup_r;
  logic [16:0]        f1_sf_r, f1_tf_r, f1_vf_r;
  logic signed [31:0] f1_p_r, f1_m1_r;
  logic signed [50:0] f1_s_r;
  logic [47:0]        f1_m2l_r, f1_m2h_r;

  always_comb begin
    alpha = (cfg.l2_mix > arp_pkg::ONE_Q16) ? arp_pkg::ONE_Q16 : cfg.l2_mix;
    ap    = $signed({1'b0, alpha}) * old_param;
    l1    = {arp_pkg::ONE_Q16 - alpha, 15'b0};
    if (old_param >= 0) begin
      s_c = $signed({ap[49], ap}) + $signed({19'b0, l1});
    end else begin
      s_c = $signed({ap[49], ap}) - $signed({19'b0, l1});
    end
  end

  always_ff @(posedge clk) begin
    if (fen) begin
      f1_coup_r <= is_coupling;
      f1_sf_r   <= sample_freq;
      f1_tf_r   <= train_freq;
      f1_vf_r   <= valid_freq;
      f1_p_r    <= old_param;
      f1_m1_r   <= old_first_moment;
      f1_s_r    <= s_c;
      f1_m2l_r  <= old_second_moment[23:0] * arp_pkg::B2_Q24;
      f1_m2h_r  <= old_second_moment[47:24] * arp_pkg::B2_Q24;
    end
  end

  // stage 2
  logic [50:0] sabs;
  logic [31:0] lam;
  logic [71:0] m2sum;
  logic        f2_coup_r, f2_ssign_r;
  logic [16:0] f2_sf_r, f2_tf_r, f2_vf_r;
  logic signed [31:0] f2_p_r, f2_m1_r;
  logic [63:0] f2_rl_r;
  logic [48:0] f2_rh_r;
  logic [47:0] f2_m2t_r;

  always_comb begin
    sabs  = f1_s_r[50] ? 51'(-f1_s_r) : 51'(f1_s_r);
    lam   = f1_coup_r ? cfg.lam_c : cfg.lam_f;
    m2sum = {f1_m2h_r, 24'b0} + {24'b0, f1_m2l_r} + 72'h80_0000;
  end

  always_ff @(posedge clk) begin
    if (fen) begin
      f2_coup_r  <= f1_coup_r;
      f2_ssign_r <= f1_s_r[50];
      f2_sf_r    <= f1_sf_r;
      f2_tf_r    <= f1_tf_r;
      f2_vf_r    <= f1_vf_r;
      f2_p_r     <= f1_p_r;
      f2_m1_r    <= f1_m1_r;
      f2_rl_r    <= lam * sabs[31:0];
      f2_rh_r    <= lam * sabs[48:32];
      f2_m2t_r   <= m2sum[71:24];
    end
  end

  // stage 3
  logic [80:0] prod;
  logic        f3_coup_r, f3_ssign_r;
  logic [16:0] f3_sf_r, f3_tf_r, f3_vf_r;
  logic signed [31:0] f3_p_r, f3_m1_r;
  logic [40:0] f3_reg_r;
  logic [47:0] f3_m2t_r;

  assign prod = {f2_rh_r, 32'b0} + {17'b0, f2_rl_r} + (81'd1 << 39);

  always_ff @(posedge clk) begin
    if (fen) begin
      f3_coup_r  <= f2_coup_r;
      f3_ssign_r <= f2_ssign_r;
      f3_sf_r    <= f2_sf_r;
      f3_tf_r    <= f2_tf_r;
      f3_vf_r    <= f2_vf_r;
      f3_p_r     <= f2_p_r;
      f3_m1_r    <= f2_m1_r;
      f3_reg_r   <= prod[80:40];
      f3_m2t_r   <= f2_m2t_r;
    end
  end

  // stage 4
  logic signed [43:0] regs;
  logic        f4_coup_r;
  logic signed [43:0] f4_dt_r, f4_dv_r;
  logic signed [31:0] f4_p_r, f4_m1_r;
  logic [47:0] f4_m2t_r;

  assign regs = f3_ssign_r ? -$signed({3'b0, f3_reg_r}) : $signed({3'b0, f3_reg_r});

  always_ff @(posedge clk) begin
    if (fen) begin
      f4_coup_r <= f3_coup_r;
      f4_dt_r   <= $signed({27'b0, f3_sf_r}) - $signed({27'b0, f3_tf_r}) + regs;
      f4_dv_r   <= $signed({27'b0, f3_sf_r}) - $signed({27'b0, f3_vf_r}) + regs;
      f4_p_r    <= f3_p_r;
      f4_m1_r   <= f3_m1_r;
      f4_m2t_r  <= f3_m2t_r;
    end
  end

  // stage 5
  logic [43:0] dtm, dvm;
  logic signed [43:0] ndt;
  logic        f5_coup_r, f5_tbig_r, f5_vbig_r;
  logic [19:0] f5_tm_r, f5_vm_r;
  logic signed [31:0] f5_g_r, f5_p_r, f5_m1_r;
  logic [47:0] f5_m2t_r;

  always_comb begin
    ndt = -f4_dt_r;
    dtm = f4_dt_r[43] ? 44'(-f4_dt_r) : 44'(f4_dt_r);
    dvm = f4_dv_r[43] ? 44'(-f4_dv_r) : 44'(f4_dv_r);
  end

  always_ff @(posedge clk) begin
    if (fen) begin
      f5_coup_r <= f4_coup_r;
      f5_g_r    <= arp_pkg::sat32({{6{ndt[43]}}, ndt});
      f5_tbig_r <= |dtm[43:20];
      f5_vbig_r <= |dvm[43:20];
      f5_tm_r   <= dtm[19:0];
      f5_vm_r   <= dvm[19:0];
      f5_p_r    <= f4_p_r;
      f5_m1_r   <= f4_m1_r;
      f5_m2t_r  <= f4_m2t_r;
    end
  end

  // stage 6
  logic signed [48:0] tg, tm1;
  logic [31:0] gm;
  logic        f6_coup_r, f6_tbig_r, f6_vbig_r;
  logic signed [49:0] f6_t_r;
  logic [63:0] f6_g2_r;
  logic [39:0] f6_tsq_r, f6_vsq_r;
  logic signed [31:0] f6_g_r, f6_p_r;
  logic [47:0] f6_m2t_r;

  always_comb begin
    tg  = f5_g_r * $signed({1'b0, arp_pkg::C1_Q16});
    tm1 = f5_m1_r * $signed({1'b0, arp_pkg::B1_Q16});
    gm  = f5_g_r[31] ? 32'(-f5_g_r) : 32'(f5_g_r);
  end

  always_ff @(posedge clk) begin
    if (fen) begin
      f6_coup_r <= f5_coup_r;
      f6_t_r    <= $signed({tg[48], tg}) + $signed({tm1[48], tm1});
      f6_g2_r   <= gm * gm;
      f6_tbig_r <= f5_tbig_r;
      f6_vbig_r <= f5_vbig_r;
      f6_tsq_r  <= f5_tm_r * f5_tm_r;
      f6_vsq_r  <= f5_vm_r * f5_vm_r;
      f6_g_r    <= f5_g_r;
      f6_p_r    <= f5_p_r;
      f6_m2t_r  <= f5_m2t_r;
    end
  end

  // stage 7
  logic signed [49:0] tr;
  logic        f7_coup_r;
  logic signed [31:0] f7_m1n_r, f7_g_r, f7_p_r;
  logic [46:0] f7_g2l_r, f7_g2h_r;
  logic [47:0] f7_tsq_r, f7_vsq_r, f7_m2t_r;

  assign tr = (f6_t_r + 50'sd32768) >>> 16;

  always_ff @(posedge clk) begin
    if (fen) begin
      f7_coup_r <= f6_coup_r;
      f7_m1n_r  <= arp_pkg::sat32(tr);
      f7_g2l_r  <= f6_g2_r[31:0] * arp_pkg::C2_Q24;
      f7_g2h_r  <= f6_g2_r[63:32] * arp_pkg::C2_Q24;
      f7_tsq_r  <= f6_tbig_r ? arp_pkg::MAX48 : {f6_tsq_r, 8'b0};
      f7_vsq_r  <= f6_vbig_r ? arp_pkg::MAX48 : {f6_vsq_r, 8'b0};
      f7_g_r    <= f6_g_r;
      f7_p_r    <= f6_p_r;
      f7_m2t_r  <= f6_m2t_r;
    end
  end

  // stage 8
  logic [79:0] gs;
  logic [47:0] gsat;
  logic [48:0] m2s;
  arp_pkg::item_t f8_r;

  always_comb begin
    gs   = {1'b0, f7_g2h_r, 32'b0} + {33'b0, f7_g2l_r} + 80'd32768;
    gsat = (|gs[79:64]) ? arp_pkg::MAX48 : gs[63:16];
    m2s  = {1'b0, f7_m2t_r} + {1'b0, gsat};
  end

  always_ff @(posedge clk) begin
    if (fen) begin
      f8_r.coup <= f7_coup_r;
      f8_r.p    <= f7_p_r;
      f8_r.m1n  <= f7_m1n_r;
      f8_r.g    <= f7_g_r;
      f8_r.m2n  <= m2s[48] ? arp_pkg::MAX48 : m2s[47:0];
      f8_r.tsq  <= f7_tsq_r;
      f8_r.vsq  <= f7_vsq_r;
    end
  end

  assign wr_item = f8_r;

endmodule

FILE: hw/rtl/arp_fifo.sv
// ----------------------------------------------------------------------------
// arp_fifo
// Short queue between the front and the back.
// ----------------------------------------------------------------------------
module arp_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           wr_en,
  input  arp_pkg::item_t wr_item,
  input  logic           rd_en,
  output arp_pkg::item_t rd_item,
  output logic           full,
  output logic           empty
);

  arp_pkg::item_t                 mem [arp_pkg::FIFO_DEPTH];
  logic [arp_pkg::FIFO_AW-1:0]    wp_r, rp_r;
  logic [arp_pkg::FIFO_AW:0]      cnt_r;

  assign full    = (cnt_r == (arp_pkg::FIFO_AW + 1)'(arp_pkg::FIFO_DEPTH));
  assign empty   = (cnt_r == '0);
  assign rd_item = mem[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (wr_en) wp_r <= wp_r + 1'b1;
      if (rd_en) rp_r <= rp_r + 1'b1;
      if (wr_en && !rd_en) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (rd_en && !wr_en) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wp_r] <= wr_item;
  end

endmodule

FILE: hw/rtl/arp_back.sv
// ----------------------------------------------------------------------------
// arp_back
// Back pipeline: bias correction, square root, divide, step and output beat.
// ----------------------------------------------------------------------------
module arp_back (
  input  logic           clk,
  input  logic           rst_n,
  input  arp_pkg::cfg_t  cfg,
  input  logic           fifo_empty,
  input  arp_pkg::item_t rd_item,
  output logic           rd_en,
  output logic           out_valid,
  input  logic           out_stall,
  output arp_pkg::item_t out_item
);

  localparam int unsigned NSQ = arp_pkg::SQ_BITS;
  localparam int unsigned NDV = arp_pkg::DIV_BITS;

  logic adv;
  logic out_v_r;

  assign adv       = !(out_v_r && out_stall);
  assign rd_en     = adv && !fifo_empty;
  assign out_valid = out_v_r;

  // correction products
  logic [31:0] m1abs;
  logic        b0_v_r;
  arp_pkg::item_t b0_it_r;
  logic [55:0] b0_mpl_r, b0_mph_r;
  logic [63:0] b0_m1c_r;

  assign m1abs = rd_item.m1n[31] ? 32'(-rd_item.m1n) : 32'(rd_item.m1n);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b0_v_r <= 1'b0;
    end else if (adv) begin
      b0_v_r <= !fifo_empty;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b0_it_r  <= rd_item;
      b0_mpl_r <= rd_item.m2n[23:0] * cfg.corr2;
      b0_mph_r <= rd_item.m2n[47:24] * cfg.corr2;
      b0_m1c_r <= m1abs * cfg.corr1;
    end
  end

  // square root, one bit a stage
  logic           sq_v_r    [NSQ+1];
  arp_pkg::item_t sq_it_r   [NSQ+1];
  logic [81:0]    sq_rem_r  [NSQ+1];
  logic [40:0]    sq_root_r [NSQ+1];
  logic [75:0]    sq_n_r    [NSQ+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_v_r[0] <= 1'b0;
    end else if (adv) begin
      sq_v_r[0] <= b0_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sq_it_r[0]   <= b0_it_r;
      sq_rem_r[0]  <= {b0_mph_r, 24'b0} + {26'b0, b0_mpl_r};
      sq_root_r[0] <= '0;
      sq_n_r[0]    <= {b0_m1c_r, 12'b0};
    end
  end

  for (genvar k = 0; k < NSQ; k++) begin : g_sq
    localparam int unsigned BI = NSQ - 1 - k;
    logic [81:0] trial;
    logic        take;
    assign trial = ({41'b0, sq_root_r[k]} << (BI + 1)) + (82'd1 << (2 * BI));
    assign take  = (sq_rem_r[k] >= trial);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sq_v_r[k+1] <= 1'b0;
      end else if (adv) begin
        sq_v_r[k+1] <= sq_v_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        sq_it_r[k+1]   <= sq_it_r[k];
        sq_n_r[k+1]    <= sq_n_r[k];
        sq_rem_r[k+1]  <= take ? sq_rem_r[k] - trial : sq_rem_r[k];
        sq_root_r[k+1] <= take ? (sq_root_r[k] | (41'd1 << BI)) : sq_root_r[k];
      end
    end
  end

  // restoring divide, one quotient bit a stage
  logic           dv_v_r   [NDV+1];
  arp_pkg::item_t dv_it_r  [NDV+1];
  logic [76:0]    dv_rem_r [NDV+1];
  logic [40:0]    dv_den_r [NDV+1];
  logic [31:0]    dv_q_r   [NDV+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_v_r[0] <= 1'b0;
    end else if (adv) begin
      dv_v_r[0] <= sq_v_r[NSQ];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dv_it_r[0]  <= sq_it_r[NSQ];
      dv_rem_r[0] <= {1'b0, sq_n_r[NSQ]};
      dv_den_r[0] <= sq_root_r[NSQ] + arp_pkg::EPS_Q28;
      dv_q_r[0]   <= '0;
    end
  end

  for (genvar k = 0; k < NDV; k++) begin : g_dv
    localparam int unsigned BI = NDV - 1 - k;
    logic [76:0] sub;
    logic        take;
    assign sub  = {36'b0, dv_den_r[k]} << BI;
    assign take = (dv_rem_r[k] >= sub);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_v_r[k+1] <= 1'b0;
      end else if (adv) begin
        dv_v_r[k+1] <= dv_v_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        dv_it_r[k+1]  <= dv_it_r[k];
        dv_den_r[k+1] <= dv_den_r[k];
        dv_rem_r[k+1] <= take ? dv_rem_r[k] - sub : dv_rem_r[k];
        dv_q_r[k+1]   <= take ? (dv_q_r[k] | (32'd1 << BI)) : dv_q_r[k];
      end
    end
  end

  // step product
  logic [31:0]    rate;
  logic           bm_v_r;
  arp_pkg::item_t bm_it_r;
  logic [63:0]    bm_prod_r;

  assign rate = dv_it_r[NDV].coup ? cfg.rate_c : cfg.rate_f;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bm_v_r <= 1'b0;
    end else if (adv) begin
      bm_v_r <= dv_v_r[NDV];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      bm_it_r   <= dv_it_r[NDV];
      bm_prod_r <= rate * dv_q_r[NDV];
    end
  end

  // parameter update and output register
  logic [64:0]        sr;
  logic signed [49:0] pn;
  arp_pkg::item_t     upd;
  arp_pkg::item_t     out_r;

  always_comb begin
    sr = {1'b0, bm_prod_r} + 65'd8388608;
    if (bm_it_r.m1n[31]) begin
      pn = 50'(bm_it_r.p) - $signed({9'b0, sr[64:24]});
    end else begin
      pn = 50'(bm_it_r.p) + $signed({9'b0, sr[64:24]});
    end
    upd   = bm_it_r;
    upd.p = arp_pkg::sat32(pn);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (adv) begin
      out_v_r <= bm_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_r <= upd;
    end
  end

  assign out_item = out_r;

endmodule

FILE: hw/rtl/adam_regularized_param_update.sv
// ----------------------------------------------------------------------------
// adam_regularized_param_update
// Adam step of one elastic-net regularised parameter element per beat.
//
//   channel  direction  handshake        payload
//   in_      input      valid / stall    flag, 3 frequencies, param, 2 moments
//   out_     output     valid / stall    param, 2 moments, gradient, 2 errors
//   cfg_     input      valid / ready    3-bit register index, 32-bit data
//
// One beat per cycle in and out, sustained unless a stall holds the flow.
// Beats pass through the front, the queue and the back, which holds the
// 41-stage square root and the 32-stage divider. Reset is synchronous and
// clears every valid bit and the queue. An output stall freezes the back;
// the front keeps taking beats until the four-entry queue fills.
// ----------------------------------------------------------------------------
module adam_regularized_param_update (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_is_coupling,
  input  logic [16:0]        in_sample_freq,
  input  logic [16:0]        in_train_freq,
  input  logic [16:0]        in_valid_freq,
  input  logic signed [31:0] in_old_param,
  input  logic signed [31:0] in_old_first_moment,
  input  logic [47:0]        in_old_second_moment,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_new_param,
  output logic signed [31:0] out_new_first_moment,
  output logic [47:0]        out_new_second_moment,
  output logic signed [31:0] out_gradient_out,
  output logic [47:0]        out_train_sq_error,
  output logic [47:0]        out_valid_sq_error,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data
);

  arp_pkg::cfg_t  cfg_r;
  arp_pkg::item_t wr_item, rd_item, out_item;
  logic           wr_en, rd_en, fifo_full, fifo_empty;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.lam_f  <= 32'd167772;
      cfg_r.lam_c  <= 32'd167772;
      cfg_r.l2_mix <= 17'd0;
      cfg_r.rate_f <= 32'd167772;
      cfg_r.rate_c <= 32'd167772;
      cfg_r.corr1  <= 32'd655360;
      cfg_r.corr2  <= 32'd65536000;
    end else if (cfg_valid && cfg_ready) begin
      case (arp_pkg::cfg_reg_t'(cfg_index))
        arp_pkg::REG_LAMBDA_FIELD:     cfg_r.lam_f  <= cfg_data;
        arp_pkg::REG_LAMBDA_COUPLING:  cfg_r.lam_c  <= cfg_data;
        arp_pkg::REG_L2_MIX:           cfg_r.l2_mix <= cfg_data[16:0];
        arp_pkg::REG_RATE_FIELD:       cfg_r.rate_f <= cfg_data;
        arp_pkg::REG_RATE_COUPLING:    cfg_r.rate_c <= cfg_data;
        arp_pkg::REG_BIAS_CORR_FIRST:  cfg_r.corr1  <= cfg_data;
        arp_pkg::REG_BIAS_CORR_SECOND: cfg_r.corr2  <= cfg_data;
        default: ;
      endcase
    end
  end

  arp_front u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg               (cfg_r),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .is_coupling       (in_is_coupling),
    .sample_freq       (in_sample_freq),
    .train_freq        (in_train_freq),
    .valid_freq        (in_valid_freq),
    .old_param         (in_old_param),
    .old_first_moment  (in_old_first_moment),
    .old_second_moment (in_old_second_moment),
    .fifo_full         (fifo_full),
    .wr_en             (wr_en),
    .wr_item           (wr_item)
  );

  arp_fifo u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (wr_en),
    .wr_item (wr_item),
    .rd_en   (rd_en),
    .rd_item (rd_item),
    .full    (fifo_full),
    .empty   (fifo_empty)
  );

  arp_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .fifo_empty (fifo_empty),
    .rd_item    (rd_item),
    .rd_en      (rd_en),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_item   (out_item)
  );

  assign out_new_param         = out_item.p;
  assign out_new_first_moment  = out_item.m1n;
  assign out_new_second_moment = out_item.m2n;
  assign out_gradient_out      = out_item.g;
  assign out_train_sq_error    = out_item.tsq;
  assign out_valid_sq_error    = out_item.vsq;

endmodule

FILE: hw/rtl/arp_checker.sv
// ----------------------------------------------------------------------------
// arp_checker
// Port-level checks on the update block, bound to the top level.
// ----------------------------------------------------------------------------
module arp_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [31:0] out_new_param,
  input logic [47:0] out_new_second_moment,
  input logic        cfg_ready
);

  a_out_idle_after_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output beat straight after reset");

  a_in_open_after_reset: assert property (@(posedge clk)
    !rst_n |=> !in_stall)
    else $error("input stalled straight after reset");

  a_cfg_always_ready: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_ready && $past(cfg_ready))
    else $error("configuration port not ready");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_new_param)
      && $stable(out_new_second_moment))
    else $error("stalled output beat changed");

endmodule

bind adam_regularized_param_update arp_checker u_arp_checker (
  .clk                   (clk),
  .rst_n                 (rst_n),
  .in_stall              (in_stall),
  .out_valid             (out_valid),
  .out_stall             (out_stall),
  .out_new_param         (out_new_param),
  .out_new_second_moment (out_new_second_moment),
  .cfg_ready             (cfg_ready)
);

FILE: tb/sv/adam_regularized_param_update_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adam_regularized_param_update_test
// Streams parameter elements through the regularised Adam update, under
// several register settings, with random gaps on the input and random stalls
// on the output. Each accepted result is checked field by field against an
// in-bench model of the fixed-point update or a stored directed result.
// ----------------------------------------------------------------------------
module adam_regularized_param_update_test;

  localparam longint unsigned LIMIT_CYCLES = 1000000;
  localparam int unsigned     N_DIR        = 14;
  localparam int unsigned     N_RAND       = 800;
  localparam logic [63:0]     SAT48        = 64'hFFFF_FFFF_FFFF;

  typedef struct {
    logic               coup;
    logic [16:0]        sf;
    logic [16:0]        tf;
    logic [16:0]        vf;
    logic signed [31:0] p;
    logic signed [31:0] m1;
    logic [47:0]        m2;
  } element_t;

  typedef struct {
    logic signed [31:0] p;
    logic signed [31:0] m1;
    logic [47:0]        m2;
    logic signed [31:0] g;
    logic [47:0]        tsq;
    logic [47:0]        vsq;
  } update_t;

  typedef struct {
    element_t el;
    bit       typed;
    update_t  res;
  } dir_row_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic               in_is_coupling = 1'b0;
  logic [16:0]        in_sample_freq = '0;
  logic [16:0]        in_train_freq = '0;
  logic [16:0]        in_valid_freq = '0;
  logic signed [31:0] in_old_param = '0;
  logic signed [31:0] in_old_first_moment = '0;
  logic [47:0]        in_old_second_moment = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic signed [31:0] out_new_param;
  logic signed [31:0] out_new_first_moment;
  logic [47:0]        out_new_second_moment;
  logic signed [31:0] out_gradient_out;
  logic [47:0]        out_train_sq_error;
  logic [47:0]        out_valid_sq_error;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [2:0]         cfg_index = '0;
  logic [31:0]        cfg_data = '0;

  logic [31:0] lam_f, lam_c, rate_f, rate_c, corr1, corr2;
  logic [16:0] mix;

  update_t        pending_updates[$];
  int unsigned    mismatches = 0;
  longint unsigned cycles = 0;
  int             hold_cycles = 0;
  bit             quiet = 1'b0;
  dir_row_t       dir_tab[N_DIR];

  adam_regularized_param_update uut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [63:0] mul_round(logic [63:0] a, logic [63:0] b, int sh,
                                            logic [63:0] mx);
    logic [127:0] w;
    w = (128'(a) * 128'(b) + (128'd1 << (sh - 1))) >> sh;
    return (w > 128'(mx)) ? mx : w[63:0];
  endfunction

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic logic [47:0] sq_delta(longint d);
    logic [63:0] m;
    m = (d < 0) ? -d : d;
    if (m >= 64'd1048576) return SAT48[47:0];
    return 48'((m * m) << 8);
  endfunction

  function automatic update_t adam_update(element_t e);
    update_t      r;
    longint       alpha, p, s, reg_v, dt, dv, g, t, m1n;
    logic [63:0]  lam, rate, smag, regmag, g2, m2n, root, den, m1mag, qv, stepmag;
    logic [127:0] prod, cand, num;
    lam = e.coup ? lam_c : lam_f;
    rate = e.coup ? rate_c : rate_f;
    alpha = (mix > 17'd65536) ? 65536 : longint'(mix);
    p = longint'(e.p);
    s = alpha * p + (65536 - alpha) * ((p >= 0) ? 32768 : -32768);
    smag = (s < 0) ? -s : s;
    regmag = mul_round(lam, smag, 40, 64'hFFFF_FFFF_FFFF_FFFF);
    reg_v = (s < 0) ? -longint'(regmag) : longint'(regmag);
    dt = longint'(e.sf) - longint'(e.tf) + reg_v;
    dv = longint'(e.sf) - longint'(e.vf) + reg_v;
    g = clamp32(-dt);
    t = g * 6554 + longint'(e.m1) * 58982;
    m1n = clamp32((t + 32768) >>> 16);
    g2 = (g < 0) ? -g : g;
    g2 = g2 * g2;
    m2n = mul_round(64'(e.m2), 64'd16760440, 24, SAT48) + mul_round(g2, 64'd16776, 16, SAT48);
    if (m2n > SAT48) m2n = SAT48;
    prod = 128'(m2n) * 128'(corr2);
    root = '0;
    for (int i = 40; i >= 0; i--) begin
      cand = 128'(root | (64'd1 << i));
      if (cand * cand <= prod) root = cand[63:0];
    end
    den = root + 64'd16;
    m1mag = (m1n < 0) ? -m1n : m1n;
    num = (128'(m1mag) * 128'(corr1)) << 12;
    prod = num / 128'(den);
    qv = (prod > 128'h0FFFF_FFFF) ? 64'hFFFF_FFFF : prod[63:0];
    stepmag = mul_round(rate, qv, 24, 64'hFFFF_FFFF_FFFF_FFFF);
    if (stepmag > (64'd1 << 40)) stepmag = 64'd1 << 40;
    r.p = 32'(clamp32((m1n < 0) ? p - longint'(stepmag) : p + longint'(stepmag)));
    r.m1 = 32'(m1n);
    r.m2 = m2n[47:0];
    r.g = 32'(g);
    r.tsq = sq_delta(dt);
    r.vsq = sq_delta(dv);
    return r;
  endfunction

  task automatic write_reg(arp_pkg::cfg_reg_t idx, logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
    case (idx)
      arp_pkg::REG_LAMBDA_FIELD:     lam_f = data;
      arp_pkg::REG_LAMBDA_COUPLING:  lam_c = data;
      arp_pkg::REG_L2_MIX:           mix = data[16:0];
      arp_pkg::REG_RATE_FIELD:       rate_f = data;
      arp_pkg::REG_RATE_COUPLING:    rate_c = data;
      arp_pkg::REG_BIAS_CORR_FIRST:  corr1 = data;
      arp_pkg::REG_BIAS_CORR_SECOND: corr2 = data;
      default: ;
    endcase
  endtask

  task automatic drain;
    while (pending_updates.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  task automatic send_element(element_t e, bit typed, update_t typed_res);
    int gap;
    gap = 0;
    if (!quiet) begin
      case ($urandom_range(0, 9))
        0, 1, 2:    gap = $urandom_range(1, 3);
        3:          gap = $urandom_range(8, 40);
        default:    gap = 0;
      endcase
    end
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_is_coupling <= e.coup;
    in_sample_freq <= e.sf;
    in_train_freq <= e.tf;
    in_valid_freq <= e.vf;
    in_old_param <= e.p;
    in_old_first_moment <= e.m1;
    in_old_second_moment <= e.m2;
    do @(posedge clk); while (in_stall);
    pending_updates.push_back(typed ? typed_res : adam_update(e));
  endtask

  function automatic logic [16:0] rand_freq();
    case ($urandom_range(0, 9))
      0:       return 17'd0;
      1:       return 17'd65536;
      2:       return 17'($urandom);
      default: return 17'($urandom_range(0, 65536));
    endcase
  endfunction

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 9))
      0:       return 32'd0;
      1:       return 32'h7FFF_FFFF;
      2:       return 32'h8000_0000;
      3, 4:    return 32'($signed($urandom_range(0, 1 << 18)) - (1 << 17));
      default: return $urandom;
    endcase
  endfunction

  function automatic element_t rand_element();
    element_t e;
    e.coup = 1'($urandom_range(0, 1));
    e.sf = rand_freq();
    e.tf = rand_freq();
    e.vf = rand_freq();
    e.p = rand_word();
    e.m1 = rand_word();
    case ($urandom_range(0, 5))
      0:       e.m2 = '0;
      1:       e.m2 = SAT48[47:0];
      2, 3:    e.m2 = 48'($urandom_range(0, 1 << 30));
      default: e.m2 = 48'({$urandom, $urandom});
    endcase
    return e;
  endfunction

  function automatic logic [31:0] rand_cfg();
    case ($urandom_range(0, 4))
      0:       return 32'd0;
      1:       return 32'hFFFF_FFFF;
      2:       return $urandom;
      default: return $urandom_range(0, 1 << 24);
    endcase
  endfunction

  // receiver stalls
  initial begin
    int run;
    run = 0;
    forever begin
      @(posedge clk);
      if (hold_cycles > 0) begin
        out_stall <= 1'b1;
        hold_cycles--;
      end else if (run > 0) begin
        run--;
      end else begin
        case ($urandom_range(0, 9))
          0, 1, 2: begin out_stall <= 1'b1; run = $urandom_range(0, 3); end
          3:       begin out_stall <= 1'b1; run = $urandom_range(10, 40); end
          4:       begin out_stall <= 1'b0; run = $urandom_range(50, 150); end
          default: begin out_stall <= 1'b0; run = $urandom_range(0, 5); end
        endcase
      end
    end
  end

  always @(posedge clk) begin
    update_t want;
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("tb: failure");
      $finish;
    end
    if (rst_n && out_valid && !out_stall) begin
      if (pending_updates.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat p=%0d", out_new_param);
      end else begin
        want = pending_updates.pop_front();
        if (want.p !== out_new_param || want.m1 !== out_new_first_moment ||
            want.m2 !== out_new_second_moment || want.g !== out_gradient_out ||
            want.tsq !== out_train_sq_error || want.vsq !== out_valid_sq_error) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch exp p=%0d m1=%0d m2=%0d g=%0d tsq=%0d vsq=%0d",
                     want.p, want.m1, want.m2, want.g, want.tsq, want.vsq);
            $display("         got p=%0d m1=%0d m2=%0d g=%0d tsq=%0d vsq=%0d",
                     out_new_param, out_new_first_moment, out_new_second_moment,
                     out_gradient_out, out_train_sq_error, out_valid_sq_error);
          end
        end
      end
    end
  end

  initial begin
    update_t none;
    element_t e;
    none = '{default: '0};
    dir_tab = '{
      '{'{1'b0, 17'd0, 17'd0, 17'd0, 32'sd0, 32'sd0, 48'd0}, 1'b1,
        '{-32'sd659, -32'sd33, 48'd27540, -32'sd328, 48'd27541504, 48'd27541504}},
      '{'{1'b0, 17'd65536, 17'd0, 17'd0, 32'sd0, 32'sd0, 48'd0}, 1'b0, none},
      '{'{1'b1, 17'd0, 17'd65536, 17'd65536, 32'sd0, 32'sd0, 48'd0}, 1'b0, none},
      '{'{1'b0, 17'h1FFFF, 17'h1FFFF, 17'd0, 32'sd65536, 32'sd0, 48'd0}, 1'b0, none},
      '{'{1'b1, 17'd0, 17'h1FFFF, 17'd12345, -32'sd65536, 32'sd0, 48'd0}, 1'b0, none},
      '{'{1'b0, 17'd100, 17'd100, 17'd100, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 48'hFFFF_FFFF_FFFF},
        1'b0, none},
      '{'{1'b1, 17'd100, 17'd100, 17'd100, 32'h8000_0000, 32'h8000_0000, 48'd0}, 1'b0, none},
      '{'{1'b0, 17'd500, 17'd500, 17'd500, 32'sd0, 32'h7FFF_FFFF, 48'd0}, 1'b0, none},
      '{'{1'b1, 17'd7, 17'd9, 17'd3, -32'sd1, 32'h8000_0000, 48'd1}, 1'b0, none},
      '{'{1'b0, 17'h15555, 17'h0AAAA, 17'h15555, 32'h5555_5555, 32'hAAAA_AAAA,
          48'h5555_5555_5555}, 1'b0, none},
      '{'{1'b1, 17'h0AAAA, 17'h15555, 17'h0AAAA, 32'hAAAA_AAAA, 32'h5555_5555,
          48'hAAAA_AAAA_AAAA}, 1'b0, none},
      '{'{1'b0, 17'd65536, 17'd65536, 17'd0, 32'sd1, 32'sd1, 48'hFFFF_FFFF_FFFF}, 1'b0, none},
      '{'{1'b1, 17'd32768, 17'd0, 17'd65536, -32'sd32768, -32'sd1, 48'd1 << 40}, 1'b0, none},
      '{'{1'b0, 17'd0, 17'd0, 17'd0, 32'sd0, 32'sd0, 48'd0}, 1'b0, none}
    };
    lam_f = 32'd167772; lam_c = 32'd167772; mix = '0;
    rate_f = 32'd167772; rate_c = 32'd167772;
    corr1 = 32'd655360; corr2 = 32'd65536000;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_tab[i]) send_element(dir_tab[i].el, dir_tab[i].typed, dir_tab[i].res);
    in_valid <= 1'b0;
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin
          write_reg(arp_pkg::REG_LAMBDA_FIELD, 32'd0);
          write_reg(arp_pkg::REG_LAMBDA_COUPLING, 32'hFFFF_FFFF);
          write_reg(arp_pkg::REG_L2_MIX, 32'd65536);
          write_reg(arp_pkg::REG_RATE_FIELD, 32'd0);
          write_reg(arp_pkg::REG_RATE_COUPLING, 32'hFFFF_FFFF);
          write_reg(arp_pkg::REG_BIAS_CORR_FIRST, 32'd65536);
          write_reg(arp_pkg::REG_BIAS_CORR_SECOND, 32'd65536);
        end
        1: begin
          write_reg(arp_pkg::REG_LAMBDA_FIELD, 32'hFFFF_FFFF);
          write_reg(arp_pkg::REG_LAMBDA_COUPLING, 32'd0);
          write_reg(arp_pkg::REG_L2_MIX, 32'h1FFFF);
          write_reg(arp_pkg::REG_RATE_FIELD, 32'hFFFF_FFFF);
          write_reg(arp_pkg::REG_RATE_COUPLING, 32'd0);
          write_reg(arp_pkg::REG_BIAS_CORR_FIRST, 32'hFFFF_FFFF);
          write_reg(arp_pkg::REG_BIAS_CORR_SECOND, 32'hFFFF_FFFF);
        end
        2: begin
          write_reg(arp_pkg::REG_L2_MIX, 32'd0);
          write_reg(arp_pkg::REG_BIAS_CORR_FIRST, 32'd0);
          write_reg(arp_pkg::REG_BIAS_CORR_SECOND, 32'd0);
        end
        default: begin
          write_reg(arp_pkg::REG_LAMBDA_FIELD, rand_cfg());
          write_reg(arp_pkg::REG_LAMBDA_COUPLING, rand_cfg());
          write_reg(arp_pkg::REG_L2_MIX, $urandom_range(0, 65536));
          write_reg(arp_pkg::REG_RATE_FIELD, rand_cfg());
          write_reg(arp_pkg::REG_RATE_COUPLING, rand_cfg());
          write_reg(arp_pkg::REG_BIAS_CORR_FIRST, $urandom_range(65536, 32'hFFFF_FFFF));
          write_reg(arp_pkg::REG_BIAS_CORR_SECOND, $urandom_range(65536, 32'hFFFF_FFFF));
        end
      endcase
      quiet = (ph == 4);
      for (int n = 0; n < N_RAND / 6; n++) begin
        if (n == 20 && ph == 3) hold_cycles = 400;
        e = rand_element();
        send_element(e, 1'b0, none);
      end
      in_valid <= 1'b0;
      drain();
    end

    if (mismatches == 0 && pending_updates.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
